>>> rtl/mndq_pkg.sv
`timescale 1ns / 1ps
// Package for the MIDI note delay queue: request and result types,
// opcode and register codes, sequencer states and register limits.
// No dependencies.
package mndq_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_TICK     = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    REG_DELAY     = 2'd0,
    REG_TRANSPOSE = 2'd1,
    REG_VELOCITY  = 2'd2
  } reg_addr_e;

  localparam logic signed [5:0] TRANSPOSE_MIN  = -6'sd24;
  localparam logic signed [5:0] TRANSPOSE_MAX  = 6'sd24;
  localparam logic [9:0]        VELOCITY_MAX   = 10'd1000;
  localparam logic [9:0]        VELOCITY_RESET = 10'd500;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  note_in;
    logic [11:0] offset_ahead;
  } in_item_t;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] note_out;
    logic [9:0] velocity_out;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SUM,
    ST_INS_WR,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FLUSH,
    ST_PACK_RD,
    ST_PACK_WR,
    ST_ADVANCE
  } state_e;

endpackage

>>> rtl/mndq_ifs.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the note delay queue.
// Depends on mndq_pkg for the payload types.
interface mndq_in_if;
  import mndq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mndq_out_if;
  import mndq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mndq_store.sv
`timescale 1ns / 1ps
// Entry store of the note delay queue: one write port, one read port
// with registered read data. No package dependency.
module mndq_store #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned TIME_BITS   = 32,
  localparam int unsigned IDX_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IDX_W-1:0]     waddr_i,
  input  logic [TIME_BITS-1:0] wdue_i,
  input  logic [8:0]           wnote_i,
  input  logic                 wkind_i,
  input  logic [IDX_W-1:0]     raddr_i,
  output logic [TIME_BITS-1:0] rdue_o,
  output logic [8:0]           rnote_o,
  output logic                 rkind_o
);

  logic [TIME_BITS-1:0] due_mem  [QUEUE_DEPTH];
  logic [8:0]           note_mem [QUEUE_DEPTH];
  logic                 kind_mem [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      due_mem[waddr_i]  <= wdue_i;
      note_mem[waddr_i] <= wnote_i;
      kind_mem[waddr_i] <= wkind_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdue_o  <= due_mem[raddr_i];
    rnote_o <= note_mem[raddr_i];
    rkind_o <= kind_mem[raddr_i];
  end

endmodule

>>> rtl/midi_note_delay_queue_unit.sv
`timescale 1ns / 1ps
// MIDI note delay queue: sequencer, shared time adder and APB registers.
// Depends on mndq_pkg, mndq_ifs and mndq_store.
//
// Usage:
//   req_i carries requests: note on, note off or a one-sample tick. A note
//   request is transposed and queued with due time count + offset + delay;
//   when the queue is full it is dropped. A tick emits every due entry on
//   rsp_o, newest first, last set on the final one, then packs the queue
//   and advances the sample count. Entries with a note of zero or below
//   leave silently.
//   req_i.ready is high only while the sequencer is idle. A note request
//   passes through ST_INS_SUM and ST_INS_WR; a tick scans each queued
//   entry, then packs the kept ones: every entry goes through the single
//   read port of the store and the one shared adder.
//   rsp_o has one output register behind a one-entry hold; a stalled
//   receiver holds the scan at the next due entry once both are full.
//   Registers (APB, byte address 4*i): delay, transpose (saturated to
//   +/-24), velocity (saturated to 1000). pready is tied high.
//   Reset (rst_ni low, asynchronous) empties the queue, clears the sample
//   count and restores register defaults; no clearing pass is needed.
module midi_note_delay_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mndq_in_if.sink                       req_i,
  mndq_out_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mndq_pkg::PADDR_W-1:0]  paddr,
  input  logic [mndq_pkg::PDATA_W-1:0]  pwdata,
  output logic [mndq_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  import mndq_pkg::*;

  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

  // configuration registers
  logic [20:0]       delay_q;
  logic signed [5:0] trn_q;
  logic [9:0]        vel_q;
  logic              cfg_we;
  logic [1:0]        reg_idx;
  logic signed [5:0] trn_wr;
  logic [9:0]        vel_wr;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign trn_wr  = pwdata[5:0];
  assign vel_wr  = pwdata[9:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      trn_q   <= '0;
      vel_q   <= VELOCITY_RESET;
    end else if (cfg_we) begin
      case (reg_addr_e'(reg_idx))
        REG_DELAY: begin
          delay_q <= pwdata[20:0];
        end
        REG_TRANSPOSE: begin
          if (trn_wr < TRANSPOSE_MIN) begin
            trn_q <= TRANSPOSE_MIN;
          end else if (trn_wr > TRANSPOSE_MAX) begin
            trn_q <= TRANSPOSE_MAX;
          end else begin
            trn_q <= trn_wr;
          end
        end
        REG_VELOCITY: begin
          vel_q <= (vel_wr > VELOCITY_MAX) ? VELOCITY_MAX : vel_wr;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_addr_e'(reg_idx))
      REG_DELAY:     prdata = {11'd0, delay_q};
      REG_TRANSPOSE: prdata = {{26{trn_q[5]}}, trn_q};
      REG_VELOCITY:  prdata = {22'd0, vel_q};
      default:       prdata = '0;
    endcase
  end

  // sequencer state
  state_e               state_q, state_d;
  logic [TIME_BITS-1:0] count_q, count_d;
  logic [TIME_BITS-1:0] acc_q, acc_d;
  logic [OCC_W-1:0]     occ_q, occ_d;
  logic [OCC_W-1:0]     sc_q, sc_d;
  logic [OCC_W-1:0]     rc_q, rc_d;
  logic [OCC_W-1:0]     wc_q, wc_d;
  logic [QUEUE_DEPTH-1:0] keep_q, keep_d;
  logic [6:0]           note_q, note_d;
  logic                 kind_q, kind_d;
  logic [11:0]          ahead_q, ahead_d;
  logic                 hold_v_q, hold_v_d;
  logic                 hold_kind_q, hold_kind_d;
  logic [7:0]           hold_note_q, hold_note_d;
  logic                 out_v_q, out_v_d;
  logic                 out_kind_q, out_kind_d;
  logic [7:0]           out_note_q, out_note_d;
  logic                 out_last_q, out_last_d;

  // shared adder
  logic [TIME_BITS-1:0] alu_a, alu_b, alu_sum;
  logic                 alu_cin;
  assign alu_sum = alu_a + alu_b + TIME_BITS'(alu_cin);

  // store ports
  logic                 st_we;
  logic [IDX_W-1:0]     st_waddr, st_raddr;
  logic [TIME_BITS-1:0] st_wdue, st_rdue;
  logic [8:0]           st_wnote, st_rnote;
  logic                 st_wkind, st_rkind;

  logic [OCC_W-1:0]     sc_m1;
  logic [IDX_W-1:0]     scan_idx;
  logic                 out_free;
  logic                 is_due;
  logic                 emit;

  mndq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdue_i  (st_wdue),
    .wnote_i (st_wnote),
    .wkind_i (st_wkind),
    .raddr_i (st_raddr),
    .rdue_o  (st_rdue),
    .rnote_o (st_rnote),
    .rkind_o (st_rkind)
  );

  assign sc_m1    = sc_q - OCC_W'(1);
  assign scan_idx = sc_m1[IDX_W-1:0];
  assign out_free = !out_v_q || rsp_o.ready;
  // due when count - due has its top bit clear (wrap-aware)
  assign is_due   = !alu_sum[TIME_BITS-1];
  assign emit     = is_due && !st_rnote[8] && (|st_rnote[7:0]);

  assign req_i.ready             = (state_q == ST_IDLE);
  assign rsp_o.valid             = out_v_q;
  assign rsp_o.data.event_kind   = out_kind_q;
  assign rsp_o.data.note_out     = out_note_q;
  assign rsp_o.data.velocity_out = vel_q;
  assign rsp_o.data.last         = out_last_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    acc_d       = acc_q;
    occ_d       = occ_q;
    sc_d        = sc_q;
    rc_d        = rc_q;
    wc_d        = wc_q;
    keep_d      = keep_q;
    note_d      = note_q;
    kind_d      = kind_q;
    ahead_d     = ahead_q;
    hold_v_d    = hold_v_q;
    hold_kind_d = hold_kind_q;
    hold_note_d = hold_note_q;
    out_v_d     = out_v_q && !rsp_o.ready;
    out_kind_d  = out_kind_q;
    out_note_d  = out_note_q;
    out_last_d  = out_last_q;

    alu_a    = count_q;
    alu_b    = TIME_BITS'(ahead_q);
    alu_cin  = 1'b0;
    st_we    = 1'b0;
    st_waddr = occ_q[IDX_W-1:0];
    st_wdue  = alu_sum;
    st_wnote = {2'b00, note_q} + {{3{trn_q[5]}}, trn_q};
    st_wkind = kind_q;
    st_raddr = scan_idx;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          note_d  = req_i.data.note_in;
          ahead_d = req_i.data.offset_ahead;
          case (opcode_e'(req_i.data.opcode))
            OP_NOTE_ON, OP_NOTE_OFF: begin
              kind_d = req_i.data.opcode[0];
              if (occ_q != OCC_W'(QUEUE_DEPTH)) begin
                state_d = ST_INS_SUM;
              end
            end
            OP_TICK: begin
              sc_d    = occ_q;
              state_d = ST_SCAN_RD;
            end
            default: begin
            end
          endcase
        end
      end

      ST_INS_SUM: begin
        acc_d   = alu_sum;
        state_d = ST_INS_WR;
      end

      ST_INS_WR: begin
        alu_a   = acc_q;
        alu_b   = TIME_BITS'(delay_q);
        st_we   = 1'b1;
        occ_d   = occ_q + OCC_W'(1);
        state_d = ST_IDLE;
      end

      ST_SCAN_RD: begin
        if (sc_q == '0) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_SCAN_EV;
        end
      end

      ST_SCAN_EV: begin
        alu_b   = ~st_rdue;
        alu_cin = 1'b1;
        if (emit && hold_v_q && !out_free) begin
          // wait for the output register
          state_d = ST_SCAN_EV;
        end else begin
          keep_d[scan_idx] = !is_due;
          if (emit) begin
            if (hold_v_q) begin
              out_v_d    = 1'b1;
              out_kind_d = hold_kind_q;
              out_note_d = hold_note_q;
              out_last_d = 1'b0;
            end
            hold_v_d    = 1'b1;
            hold_kind_d = st_rkind;
            hold_note_d = st_rnote[7:0];
          end
          sc_d    = sc_m1;
          state_d = ST_SCAN_RD;
        end
      end

      ST_FLUSH: begin
        if (!hold_v_q || out_free) begin
          if (hold_v_q) begin
            out_v_d    = 1'b1;
            out_kind_d = hold_kind_q;
            out_note_d = hold_note_q;
            out_last_d = 1'b1;
            hold_v_d   = 1'b0;
          end
          rc_d    = '0;
          wc_d    = '0;
          state_d = ST_PACK_RD;
        end
      end

      ST_PACK_RD: begin
        st_raddr = rc_q[IDX_W-1:0];
        if (rc_q == occ_q) begin
          occ_d   = wc_q;
          state_d = ST_ADVANCE;
        end else if (keep_q[rc_q[IDX_W-1:0]]) begin
          state_d = ST_PACK_WR;
        end else begin
          rc_d = rc_q + OCC_W'(1);
        end
      end

      ST_PACK_WR: begin
        st_raddr = rc_q[IDX_W-1:0];
        st_we    = 1'b1;
        st_waddr = wc_q[IDX_W-1:0];
        st_wdue  = st_rdue;
        st_wnote = st_rnote;
        st_wkind = st_rkind;
        wc_d     = wc_q + OCC_W'(1);
        rc_d     = rc_q + OCC_W'(1);
        state_d  = ST_PACK_RD;
      end

      ST_ADVANCE: begin
        alu_b   = '0;
        alu_cin = 1'b1;
        count_d = alu_sum;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      occ_q    <= '0;
      sc_q     <= '0;
      rc_q     <= '0;
      wc_q     <= '0;
      keep_q   <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      occ_q    <= occ_d;
      sc_q     <= sc_d;
      rc_q     <= rc_d;
      wc_q     <= wc_d;
      keep_q   <= keep_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    note_q      <= note_d;
    kind_q      <= kind_d;
    ahead_q     <= ahead_d;
    hold_kind_q <= hold_kind_d;
    hold_note_q <= hold_note_d;
    out_kind_q  <= out_kind_d;
    out_note_q  <= out_note_d;
    out_last_q  <= out_last_d;
  end

endmodule

>>> bench/tb_midi_note_delay_queue_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for midi_note_delay_queue_unit: directed and random note/tick requests,
// APB register writes, a queue predictor in a small scoreboard class, and random idling phases.
// Depends on mndq_pkg, mndq_ifs and the unit itself.
module tb_midi_note_delay_queue_unit;
  import mndq_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = 32;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned SETTLE_CYCLES = 160;   // outlasts the longest tick
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [1:0]  REG_UNMAPPED  = 2'd3;

  class note_delay_scoreboard;
    logic [31:0]       samples_elapsed;
    int unsigned       occupancy;
    logic [31:0]       due_at[QUEUE_DEPTH];
    logic signed [8:0] note_at[QUEUE_DEPTH];
    logic              kind_at[QUEUE_DEPTH];
    logic [20:0]       delay;
    logic signed [5:0] semitones;
    logic [9:0]        velocity;
    out_item_t         due_events[$];
    int unsigned       mismatches, checked, requests, ticks, dropped;

    function new();
      samples_elapsed = '0;
      occupancy       = 0;
      delay           = '0;
      semitones       = '0;
      velocity        = VELOCITY_RESET;
      mismatches      = 0;
      checked         = 0;
      requests        = 0;
      ticks           = 0;
      dropped         = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [31:0] value);
      logic signed [5:0] shift;
      logic [9:0]        level;
      shift = value[5:0];
      level = value[9:0];
      case (index)
        REG_DELAY:     delay = value[20:0];
        REG_TRANSPOSE: semitones = (shift < TRANSPOSE_MIN) ? TRANSPOSE_MIN :
                                   (shift > TRANSPOSE_MAX) ? TRANSPOSE_MAX : shift;
        REG_VELOCITY:  velocity = (level > VELOCITY_MAX) ? VELOCITY_MAX : level;
        default: ;
      endcase
    endfunction

    function void accept_request(in_item_t req);
      out_item_t   burst[$];
      out_item_t   ev;
      logic [31:0] lag;
      int          n;
      bit          keep[QUEUE_DEPTH];
      int unsigned w;
      requests++;
      case (req.opcode)
        OP_NOTE_ON, OP_NOTE_OFF: begin
          if (occupancy >= QUEUE_DEPTH) begin
            dropped++;
          end else begin
            due_at[occupancy] = samples_elapsed + 32'(req.offset_ahead) + 32'(delay);
            n = int'(req.note_in) + int'(semitones);
            note_at[occupancy] = 9'(n);
            kind_at[occupancy] = req.opcode[0];
            occupancy++;
          end
        end
        OP_TICK: begin
          ticks++;
          // newest first; due once the wrapped difference is non-negative
          for (int k = int'(occupancy) - 1; k >= 0; k--) begin
            lag = samples_elapsed - due_at[k];
            keep[k] = lag[31];
            if (!lag[31] && note_at[k] > 9'sd0) begin
              ev.event_kind   = kind_at[k];
              ev.note_out     = note_at[k][7:0];
              ev.velocity_out = velocity;
              ev.last         = 1'b0;
              burst = {burst, ev};
            end
          end
          foreach (burst[i]) begin
            ev = burst[i];
            ev.last = (i == burst.size() - 1);
            due_events = {due_events, ev};
          end
          w = 0;
          for (int k = 0; k < int'(occupancy); k++) begin
            if (keep[k]) begin
              due_at[w]  = due_at[k];
              note_at[w] = note_at[k];
              kind_at[w] = kind_at[k];
              w++;
            end
          end
          occupancy = w;
          samples_elapsed++;
        end
        default: ;
      endcase
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      checked++;
      if (due_events.size() == 0) begin
        flag($sformatf("unexpected event kind %0d note %0d velocity %0d last %0d",
                       got.event_kind, got.note_out, got.velocity_out, got.last));
        return;
      end
      want = due_events.pop_front();
      if (got.event_kind !== want.event_kind || got.note_out !== want.note_out ||
          got.velocity_out !== want.velocity_out || got.last !== want.last)
        flag($sformatf("expected kind %0d note %0d velocity %0d last %0d, got %0d %0d %0d %0d",
                       want.event_kind, want.note_out, want.velocity_out, want.last,
                       got.event_kind, got.note_out, got.velocity_out, got.last));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  int unsigned         send_idle_pct;
  int unsigned         rsp_stall_pct;

  note_delay_scoreboard board = new();

  mndq_in_if  req_ch ();
  mndq_out_if evt_ch ();

  midi_note_delay_queue_unit #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_ch),
    .rsp_o   (evt_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: check on the handshake edge, then pick the next ready
  initial begin
    evt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (evt_ch.valid && evt_ch.ready) board.check_event(evt_ch.data);
      evt_ch.ready <= !(rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles, %0d events still outstanding",
             cycles, board.due_events.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_register(index, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [31:0] delay, input logic [31:0] shift,
                               input logic [31:0] level);
    write_reg(REG_DELAY, delay);
    write_reg(REG_TRANSPOSE, shift);
    write_reg(REG_VELOCITY, level);
  endtask

  task automatic send_request(input in_item_t item);
    // valid is only lowered when a gap follows, never in the step that raises it
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do @(posedge clk); while (!req_ch.ready);
    board.accept_request(item);
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [6:0] note,
                             input logic [11:0] ahead);
    in_item_t item;
    item.opcode       = op;
    item.note_in      = note;
    item.offset_ahead = ahead;
    send_request(item);
  endtask

  task automatic finish_phase();
    req_ch.valid <= 1'b0;
    while (board.due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t random_request();
    in_item_t    r;
    int unsigned pick;
    pick           = $urandom_range(0, 99);
    r.note_in      = 7'($urandom_range(0, 127));
    // a long offset now and then; most of them hold a slot for the rest of the run
    r.offset_ahead = ($urandom_range(0, 39) == 0) ? 12'($urandom_range(0, 4095))
                                                  : 12'($urandom_range(0, 5));
    if (pick < 46)      r.opcode = OP_TICK;
    else if (pick < 72) r.opcode = OP_NOTE_ON;
    else if (pick < 97) r.opcode = OP_NOTE_OFF;
    else                r.opcode = OP_UNUSED;
    return r;
  endfunction

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                  input bit fill_first, input int unsigned count);
    int unsigned sent;
    in_item_t    item;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    sent = 0;
    if (fill_first) begin
      // overfill the queue, then flush whatever is due in two ticks
      repeat (QUEUE_DEPTH + 2) begin
        send_fields($urandom_range(0, 1) ? OP_NOTE_OFF : OP_NOTE_ON,
                    7'($urandom_range(0, 127)), 12'($urandom_range(0, 1)));
        sent++;
      end
      repeat (2) begin
        send_fields(OP_TICK, 7'($urandom_range(0, 127)), 12'($urandom_range(0, 4095)));
        sent++;
      end
    end
    while (sent < count) begin
      item = random_request();
      send_request(item);
      if (item.opcode != OP_UNUSED) sent++;
    end
    finish_phase();
  endtask

  initial begin
    rst_n         <= 1'b0;
    req_ch.valid  <= 1'b0;
    req_ch.data   <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: empty tick, a silent zero note, an offset of one, unknown opcode
    send_fields(OP_TICK, 7'd0, 12'd0);
    send_fields(OP_NOTE_ON, 7'd127, 12'd0);
    send_fields(OP_NOTE_OFF, 7'd0, 12'd0);
    send_fields(OP_NOTE_ON, 7'd1, 12'd1);
    send_fields(OP_TICK, 7'd0, 12'd0);
    send_fields(OP_TICK, 7'd0, 12'd0);
    send_fields(OP_UNUSED, 7'd127, 12'd4095);
    send_fields(OP_NOTE_OFF, 7'd64, 12'd4095);
    finish_phase();

    // transpose below range saturates to -24, velocity above 1000 saturates
    write_reg(REG_TRANSPOSE, 32'h0000_0020);
    write_reg(REG_VELOCITY, 32'h0000_03FF);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_fields(OP_NOTE_ON, 7'd24, 12'd0);
    send_fields(OP_NOTE_ON, 7'd25, 12'd0);
    send_fields(OP_NOTE_OFF, 7'd0, 12'd0);
    send_fields(OP_NOTE_OFF, 7'd85, 12'd2);
    repeat (3) send_fields(OP_TICK, 7'd127, 12'd0);
    finish_phase();

    // transpose above range saturates to +24: note 127 leaves as 151
    set_registers(32'd2, 32'h0000_001F, 32'd0);
    send_fields(OP_NOTE_ON, 7'd127, 12'd0);
    send_fields(OP_NOTE_OFF, 7'd42, 12'd1);
    repeat (4) send_fields(OP_TICK, 7'd0, 12'd0);
    finish_phase();

    set_registers(32'd0, 32'd0, 32'd500);
    run_random_phase(0, 0, 1'b1, 80);
    set_registers(32'd1, 32'd7, 32'd1);
    run_random_phase(79, 0, 1'b0, 80);
    set_registers(32'd0, -32'sd24, 32'd1000);
    run_random_phase(0, 79, 1'b1, 85);
    set_registers(32'd3, 32'd24, 32'd777);
    run_random_phase(31, 31, 1'b0, 85);
    // all delay bits set: nothing queued from here on comes due within the run
    set_registers(32'h001F_FFFF, 32'h0000_003F, 32'd1000);
    run_random_phase(31, 31, 1'b0, 10);

    $display("Covered %0d requests (%0d ticks, %0d notes dropped on a full queue)",
             board.requests, board.ticks, board.dropped);
    $display("and checked %0d note events over five idling phases and eight register settings",
             board.checked);
    if (board.mismatches == 0 && board.due_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d events never arrived",
               board.mismatches, board.due_events.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mndq_pkg.sv
rtl/mndq_ifs.sv
rtl/mndq_store.sv
rtl/midi_note_delay_queue_unit.sv
bench/tb_midi_note_delay_queue_unit.sv
